FILE: hw/rtl/ljpf_pkg.sv
package ljpf_pkg;

  typedef struct packed {
    logic        start_of_pass;
    logic [15:0] first_atom;
    logic [15:0] second_atom;
    logic [31:0] first_pos_x;
    logic [31:0] first_pos_y;
    logic [31:0] first_pos_z;
    logic [31:0] second_pos_x;
    logic [31:0] second_pos_y;
    logic [31:0] second_pos_z;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_first_atom;
    logic [15:0] out_second_atom;
    logic        within_cutoff;
    logic [31:0] force_x;
    logic [31:0] force_y;
    logic [31:0] force_z;
    logic [31:0] energy_total;
    logic [31:0] virial_total;
  } out_item_t;

  typedef struct packed {
    logic [31:0] box_x;
    logic [31:0] box_y;
    logic [31:0] box_z;
    logic [31:0] cutoff_sq;
  } cfg_t;

  typedef enum logic [1:0] {
    REG_BOX_X  = 2'd0,
    REG_BOX_Y  = 2'd1,
    REG_BOX_Z  = 2'd2,
    REG_CUTOFF = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    FOP_ADD,
    FOP_SUB,
    FOP_MUL,
    FOP_DIV
  } fpu_op_e;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_PREP,
    FS_DIV,
    FS_NORM,
    FS_RND
  } fpu_state_e;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_ISSUE,
    SQ_WAIT,
    SQ_OUT
  } seq_state_e;

  typedef enum logic [4:0] {
    S_DX, S_DY, S_DZ,
    S_HX, S_WX, S_HY, S_WY, S_HZ, S_WZ,
    S_RR, S_T1, S_RR2, S_T2, S_RR3, S_CUT,
    S_R2, S_R6A, S_R6B, S_A1, S_F1, S_F2, S_F3,
    S_FX, S_FY, S_FZ, S_A2, S_E1, S_E2, S_EACC, S_E3, S_VACC
  } step_e;

  typedef struct packed {
    logic        start;
    fpu_op_e     op;
    logic [31:0] a;
    logic [31:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } fpu_rsp_t;

  localparam logic [31:0] BOX_RESET = 32'h4120_0000;
  localparam logic [31:0] CUT_RESET = 32'h40C8_0000;
  localparam logic [31:0] F_ZERO    = 32'h0000_0000;
  localparam logic [31:0] F_HALF    = 32'h3F00_0000;
  localparam logic [31:0] F_ONE     = 32'h3F80_0000;
  localparam logic [31:0] F_FOUR    = 32'h4080_0000;
  localparam logic [31:0] F_48      = 32'h4240_0000;
  localparam logic [31:0] F_DNAN    = 32'hFFC0_0000;

  function automatic logic fp_is_nan(logic [31:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
  endfunction

  // ordered less-than; false on any NaN, +0 and -0 equal
  function automatic logic fp_lt(logic [31:0] a, logic [31:0] b);
    logic [31:0] ka;
    logic [31:0] kb;
    logic        r;
    ka = a[31] ? ~a : (a | 32'h8000_0000);
    kb = b[31] ? ~b : (b | 32'h8000_0000);
    r  = (ka < kb);
    if (fp_is_nan(a) || fp_is_nan(b)) r = 1'b0;
    if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) r = 1'b0;
    return r;
  endfunction

endpackage

FILE: hw/rtl/ljpf_queue.sv
module ljpf_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ljpf_pkg::in_item_t in_item_i,
  output logic               out_valid_o,
  output ljpf_pkg::in_item_t out_item_o,
  input  logic               pop_i
);
  import ljpf_pkg::*;

  in_item_t   ent_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = ent_q[rd_q];
  assign push        = in_valid_i & in_ready_o;
  assign pop         = pop_i & out_valid_o;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (!push && pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_q] <= in_item_i;
  end

endmodule

FILE: hw/rtl/ljpf_fpu.sv
module ljpf_fpu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ljpf_pkg::fpu_req_t req_i,
  output ljpf_pkg::fpu_rsp_t rsp_o
);
  import ljpf_pkg::*;

  function automatic logic [5:0] clz48(logic [47:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  function automatic logic [4:0] clz24(logic [23:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

  // m has its leading one at bit 47; e is the biased exponent of that bit
  function automatic logic [31:0] round_pack(logic s, logic signed [11:0] e, logic [47:0] m);
    logic signed [11:0] sh;
    logic [47:0]        ms;
    logic               lost;
    logic [7:0]         ef;
    logic               up;
    logic [30:0]        pk;
    logic [31:0]        r;
    sh   = 12'sd1 - e;
    ms   = m;
    lost = 1'b0;
    ef   = e[7:0];
    if (e < 12'sd1) begin
      ef = 8'd0;
      if (sh >= 12'sd48) begin
        ms   = 48'd0;
        lost = |m;
      end else begin
        ms   = m >> sh[5:0];
        lost = |(m & ((48'd1 << sh[5:0]) - 48'd1));
      end
    end
    up = ms[23] & (lost | (|ms[22:0]) | ms[24]);
    pk = {ef, ms[46:24]} + {30'd0, up};
    r  = {s, pk};
    if (e > 12'sd254) r = {s, 8'hFF, 23'd0};
    return r;
  endfunction

  fpu_state_e         state_q, state_d;
  fpu_op_e            op_q, op_d;
  logic [31:0]        a_q, a_d, b_q, b_d, res_q, res_d;
  logic               done_q, done_d, sgn_q, sgn_d;
  logic signed [11:0] exp_q, exp_d;
  logic [47:0]        man_q, man_d;
  logic [25:0]        rem_q, rem_d, quo_q, quo_d;
  logic [23:0]        dvs_q, dvs_d;
  logic [4:0]         cnt_q, cnt_d;

  logic [31:0]        bx, xo, yo, sp_inf;
  logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, ps;
  logic [23:0]        ma, mb, mx, my;
  logic signed [11:0] ea, eb;
  logic [7:0]         exf, eyf, dsh;
  logic [47:0]        xa, ya, ys, sum, prod;
  logic               yst, eff;
  logic [4:0]         lza, lzb;
  logic [5:0]         lzn;
  logic               ge;
  logic [25:0]        rsub;

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

  always_comb begin
    bx     = (op_q == FOP_SUB) ? {~b_q[31], b_q[30:0]} : b_q;
    a_nan  = fp_is_nan(a_q);
    b_nan  = fp_is_nan(b_q);
    a_inf  = (a_q[30:0] == 31'h7F80_0000);
    b_inf  = (bx[30:0] == 31'h7F80_0000);
    a_zero = (a_q[30:0] == 31'd0);
    b_zero = (bx[30:0] == 31'd0);
    ma     = {|a_q[30:23], a_q[22:0]};
    mb     = {|bx[30:23], bx[22:0]};
    ea     = (a_q[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, a_q[30:23]});
    eb     = (bx[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, bx[30:23]});
    ps     = a_q[31] ^ bx[31];
    sp_inf = {ps, 8'hFF, 23'd0};
    // add path: larger magnitude first, align the smaller with sticky
    xo     = (bx[30:0] > a_q[30:0]) ? bx : a_q;
    yo     = (bx[30:0] > a_q[30:0]) ? a_q : bx;
    exf    = (xo[30:23] == 8'd0) ? 8'd1 : xo[30:23];
    eyf    = (yo[30:23] == 8'd0) ? 8'd1 : yo[30:23];
    mx     = {|xo[30:23], xo[22:0]};
    my     = {|yo[30:23], yo[22:0]};
    dsh    = exf - eyf;
    xa     = {1'b0, mx, 23'd0};
    ya     = {1'b0, my, 23'd0};
    if (dsh >= 8'd48) begin
      ys  = 48'd0;
      yst = |my;
    end else begin
      ys  = ya >> dsh[5:0];
      yst = |(ya & ((48'd1 << dsh[5:0]) - 48'd1));
    end
    eff    = xo[31] ^ yo[31];
    sum    = eff ? (xa - (ys | {47'd0, yst})) : (xa + (ys | {47'd0, yst}));
    prod   = ma * mb;
    lza    = clz24(ma);
    lzb    = clz24(mb);
    lzn    = clz48(man_q);
    ge     = (rem_q >= {2'd0, dvs_q});
    rsub   = ge ? (rem_q - {2'd0, dvs_q}) : rem_q;
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    a_d     = a_q;
    b_d     = b_q;
    res_d   = res_q;
    done_d  = 1'b0;
    sgn_d   = sgn_q;
    exp_d   = exp_q;
    man_d   = man_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    case (state_q)
      FS_IDLE: begin
        if (req_i.start) begin
          op_d    = req_i.op;
          a_d     = req_i.a;
          b_d     = req_i.b;
          state_d = FS_PREP;
        end
      end
      FS_PREP: begin
        state_d = FS_IDLE;
        if (a_nan || b_nan) begin
          res_d  = a_nan ? (a_q | 32'h0040_0000) : (b_q | 32'h0040_0000);
          done_d = 1'b1;
        end else begin
          case (op_q)
            FOP_ADD, FOP_SUB: begin
              done_d = 1'b1;
              if (a_inf || b_inf) begin
                if (a_inf && b_inf && ps) res_d = F_DNAN;
                else res_d = {a_inf ? a_q[31] : bx[31], 8'hFF, 23'd0};
              end else if (sum == 48'd0) begin
                res_d = {~eff & xo[31], 31'd0};
              end else begin
                done_d  = 1'b0;
                sgn_d   = xo[31];
                exp_d   = $signed({4'd0, exf}) + 12'sd1;
                man_d   = sum;
                state_d = FS_NORM;
              end
            end
            FOP_MUL: begin
              done_d = 1'b1;
              if (a_inf || b_inf) begin
                res_d = ((a_inf && b_zero) || (b_inf && a_zero)) ? F_DNAN : sp_inf;
              end else if (a_zero || b_zero) begin
                res_d = {ps, 31'd0};
              end else begin
                done_d  = 1'b0;
                sgn_d   = ps;
                exp_d   = ea + eb - 12'sd126;
                man_d   = prod;
                state_d = FS_NORM;
              end
            end
            default: begin
              done_d = 1'b1;
              if (a_inf) begin
                res_d = b_inf ? F_DNAN : sp_inf;
              end else if (b_inf) begin
                res_d = {ps, 31'd0};
              end else if (b_zero) begin
                res_d = a_zero ? F_DNAN : sp_inf;
              end else if (a_zero) begin
                res_d = {ps, 31'd0};
              end else begin
                done_d  = 1'b0;
                sgn_d   = ps;
                exp_d   = (ea - $signed({7'd0, lza})) - (eb - $signed({7'd0, lzb}))
                          + 12'sd127;
                rem_d   = {2'd0, 24'(ma << lza)};
                dvs_d   = 24'(mb << lzb);
                quo_d   = 26'd0;
                cnt_d   = 5'd0;
                state_d = FS_DIV;
              end
            end
          endcase
        end
      end
      FS_DIV: begin
        // restoring divide, one quotient bit per cycle
        quo_d = {quo_q[24:0], ge};
        rem_d = {rsub[24:0], 1'b0};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd25) begin
          man_d   = {quo_q[24:0], ge, |rsub, 21'd0};
          state_d = FS_NORM;
        end
      end
      FS_NORM: begin
        man_d   = man_q << lzn;
        exp_d   = exp_q - $signed({6'd0, lzn});
        state_d = FS_RND;
      end
      FS_RND: begin
        res_d   = round_pack(sgn_q, exp_q, man_q);
        done_d  = 1'b1;
        state_d = FS_IDLE;
      end
      default: state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    a_q   <= a_d;
    b_q   <= b_d;
    res_q <= res_d;
    sgn_q <= sgn_d;
    exp_q <= exp_d;
    man_q <= man_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    cnt_q <= cnt_d;
  end

endmodule

FILE: hw/rtl/ljpf_seq.sv
module ljpf_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ljpf_pkg::cfg_t      cfg_i,
  input  logic                q_valid_i,
  input  ljpf_pkg::in_item_t  q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ljpf_pkg::out_item_t out_item_o
);
  import ljpf_pkg::*;

  seq_state_e  state_q, state_d;
  step_e       step_q, step_d;
  in_item_t    item_q, item_d;
  out_item_t   out_q, out_d;
  logic        out_valid_q, out_valid_d;
  logic        within_q, within_d;
  logic [31:0] dx_q, dx_d, dy_q, dy_d, dz_q, dz_d, h_q, h_d, rr_q, rr_d, t_q, t_d;
  logic [31:0] r2_q, r2_d, r6_q, r6_d, a_q, a_d, f_q, f_d, e_q, e_d;
  logic [31:0] fx_q, fx_d, fy_q, fy_d, fz_q, fz_d, eacc_q, eacc_d, vacc_q, vacc_d;

  fpu_req_t    req;
  fpu_rsp_t    rsp;
  fpu_op_e     iop;
  logic [31:0] ia, ib, nh, wd, wl;
  logic        iskip, istop;

  ljpf_fpu u_fpu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // operation for the current step; wrap steps pick add, subtract or nothing
  always_comb begin
    iop   = FOP_MUL;
    ia    = F_ZERO;
    ib    = F_ZERO;
    iskip = 1'b0;
    istop = 1'b0;
    nh    = {~h_q[31], h_q[30:0]};
    case (step_q)
      S_WX:    begin wd = dx_q; wl = cfg_i.box_x; end
      S_WY:    begin wd = dy_q; wl = cfg_i.box_y; end
      default: begin wd = dz_q; wl = cfg_i.box_z; end
    endcase
    case (step_q)
      S_DX:  begin iop = FOP_SUB; ia = item_q.first_pos_x; ib = item_q.second_pos_x; end
      S_DY:  begin iop = FOP_SUB; ia = item_q.first_pos_y; ib = item_q.second_pos_y; end
      S_DZ:  begin iop = FOP_SUB; ia = item_q.first_pos_z; ib = item_q.second_pos_z; end
      S_HX:  begin ia = F_HALF; ib = cfg_i.box_x; end
      S_HY:  begin ia = F_HALF; ib = cfg_i.box_y; end
      S_HZ:  begin ia = F_HALF; ib = cfg_i.box_z; end
      S_WX, S_WY, S_WZ: begin
        ia = wd;
        ib = wl;
        if (fp_lt(wd, nh)) iop = FOP_ADD;
        else if (fp_lt(h_q, wd)) iop = FOP_SUB;
        else iskip = 1'b1;
      end
      S_RR:  begin ia = dx_q; ib = dx_q; end
      S_T1:  begin ia = dy_q; ib = dy_q; end
      S_RR2: begin iop = FOP_ADD; ia = rr_q; ib = t_q; end
      S_T2:  begin ia = dz_q; ib = dz_q; end
      S_RR3: begin iop = FOP_ADD; ia = rr_q; ib = t_q; end
      S_CUT: begin
        if (fp_lt(F_ZERO, rr_q) && fp_lt(rr_q, cfg_i.cutoff_sq)) iskip = 1'b1;
        else istop = 1'b1;
      end
      S_R2:   begin iop = FOP_DIV; ia = F_ONE; ib = rr_q; end
      S_R6A:  begin ia = r2_q; ib = r2_q; end
      S_R6B:  begin ia = r6_q; ib = r2_q; end
      S_A1:   begin iop = FOP_SUB; ia = r6_q; ib = F_HALF; end
      S_F1:   begin ia = F_48; ib = r6_q; end
      S_F2:   begin ia = f_q; ib = a_q; end
      S_F3:   begin ia = f_q; ib = r2_q; end
      S_FX:   begin ia = f_q; ib = dx_q; end
      S_FY:   begin ia = f_q; ib = dy_q; end
      S_FZ:   begin ia = f_q; ib = dz_q; end
      S_A2:   begin iop = FOP_SUB; ia = r6_q; ib = F_ONE; end
      S_E1:   begin ia = F_FOUR; ib = r6_q; end
      S_E2:   begin ia = e_q; ib = a_q; end
      S_EACC: begin iop = FOP_ADD; ia = eacc_q; ib = e_q; end
      S_E3:   begin ia = f_q; ib = rr_q; end
      S_VACC: begin iop = FOP_ADD; ia = vacc_q; ib = e_q; end
      default: istop = 1'b1;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    item_d      = item_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    within_d    = within_q;
    dx_d = dx_q;  dy_d = dy_q;  dz_d = dz_q;  h_d = h_q;  rr_d = rr_q;  t_d = t_q;
    r2_d = r2_q;  r6_d = r6_q;  a_d = a_q;  f_d = f_q;  e_d = e_q;
    fx_d = fx_q;  fy_d = fy_q;  fz_d = fz_q;
    eacc_d = eacc_q;
    vacc_d = vacc_q;
    q_pop_o   = 1'b0;
    req.start = 1'b0;
    req.op    = iop;
    req.a     = ia;
    req.b     = ib;
    case (state_q)
      SQ_IDLE: begin
        if (q_valid_i) begin
          q_pop_o  = 1'b1;
          item_d   = q_item_i;
          within_d = 1'b0;
          fx_d     = F_ZERO;
          fy_d     = F_ZERO;
          fz_d     = F_ZERO;
          if (q_item_i.start_of_pass) begin
            eacc_d = F_ZERO;
            vacc_d = F_ZERO;
          end
          step_d  = S_DX;
          state_d = SQ_ISSUE;
        end
      end
      SQ_ISSUE: begin
        if (istop) begin
          state_d = SQ_OUT;
        end else if (iskip) begin
          if (step_q == S_CUT) within_d = 1'b1;
          step_d = step_e'(5'(step_q + 5'd1));
        end else begin
          req.start = 1'b1;
          state_d   = SQ_WAIT;
        end
      end
      SQ_WAIT: begin
        if (rsp.done) begin
          case (step_q)
            S_DX, S_WX:             dx_d = rsp.res;
            S_DY, S_WY:             dy_d = rsp.res;
            S_DZ, S_WZ:             dz_d = rsp.res;
            S_HX, S_HY, S_HZ:       h_d  = rsp.res;
            S_RR, S_RR2, S_RR3:     rr_d = rsp.res;
            S_T1, S_T2:             t_d  = rsp.res;
            S_R2:                   r2_d = rsp.res;
            S_R6A, S_R6B:           r6_d = rsp.res;
            S_A1, S_A2:             a_d  = rsp.res;
            S_F1, S_F2, S_F3:       f_d  = rsp.res;
            S_FX:                   fx_d = rsp.res;
            S_FY:                   fy_d = rsp.res;
            S_FZ:                   fz_d = rsp.res;
            S_E1, S_E2, S_E3:       e_d  = rsp.res;
            S_EACC:                 eacc_d = rsp.res;
            default:                vacc_d = rsp.res;
          endcase
          if (step_q == S_VACC) state_d = SQ_OUT;
          else begin
            step_d  = step_e'(5'(step_q + 5'd1));
            state_d = SQ_ISSUE;
          end
        end
      end
      SQ_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.out_first_atom  = item_q.first_atom;
          out_d.out_second_atom = item_q.second_atom;
          out_d.within_cutoff   = within_q;
          out_d.force_x         = fx_q;
          out_d.force_y         = fy_q;
          out_d.force_z         = fz_q;
          out_d.energy_total    = eacc_q;
          out_d.virial_total    = vacc_q;
          out_valid_d           = 1'b1;
          state_d               = SQ_IDLE;
        end
      end
      default: state_d = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SQ_IDLE;
      step_q      <= S_DX;
      out_valid_q <= 1'b0;
      eacc_q      <= F_ZERO;
      vacc_q      <= F_ZERO;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      eacc_q      <= eacc_d;
      vacc_q      <= vacc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    out_q    <= out_d;
    within_q <= within_d;
    dx_q <= dx_d;  dy_q <= dy_d;  dz_q <= dz_d;  h_q <= h_d;  rr_q <= rr_d;  t_q <= t_d;
    r2_q <= r2_d;  r6_q <= r6_d;  a_q <= a_d;  f_q <= f_d;  e_q <= e_d;
    fx_q <= fx_d;  fy_q <= fy_d;  fz_q <= fz_d;
  end

endmodule

FILE: hw/rtl/lj_pair_force_top.sv
// channel   | handshake                  | payload
// ----------+----------------------------+---------------------------
// pair in   | in_valid_i / in_ready_o    | in_item_i  (in_item_t)
// result    | out_valid_o / out_ready_i  | out_item_o (out_item_t)
// config    | psel penable pwrite pready | paddr pwdata prdata
//
// A pair outside the cutoff stops after the cutoff test. Each float op goes
// through the one shared FPU, which finishes early when an operand or the sum
// is zero, infinite or NaN; the reciprocal makes one quotient bit per cycle; a
// skipped wrap or the cutoff test issues no FPU op. The pair is popped first
// and the output register loaded last. A two-entry queue takes requests while
// the back end works; a result waiting in the output register stalls only the
// finish of the next pair. Reset clears the sums and restores default config.
module lj_pair_force_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ljpf_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ljpf_pkg::out_item_t out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import ljpf_pkg::*;

  cfg_t     cfg_q, cfg_d;
  in_item_t q_item;
  logic     q_valid, q_pop;
  reg_idx_e ridx;

  assign pready = 1'b1;
  assign ridx   = reg_idx_e'(paddr[3:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      case (ridx)
        REG_BOX_X:  cfg_d.box_x     = pwdata;
        REG_BOX_Y:  cfg_d.box_y     = pwdata;
        REG_BOX_Z:  cfg_d.box_z     = pwdata;
        default:    cfg_d.cutoff_sq = pwdata;
      endcase
    end
    case (ridx)
      REG_BOX_X:  prdata = cfg_q.box_x;
      REG_BOX_Y:  prdata = cfg_q.box_y;
      REG_BOX_Z:  prdata = cfg_q.box_z;
      default:    prdata = cfg_q.cutoff_sq;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{box_x: BOX_RESET, box_y: BOX_RESET, box_z: BOX_RESET,
                 cutoff_sq: CUT_RESET};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ljpf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (q_valid),
    .out_item_o  (q_item),
    .pop_i       (q_pop)
  );

  ljpf_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: hw/rtl/ljpf_checker.sv
module ljpf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ljpf_pkg::out_item_t out_item_o,
  input logic                psel,
  input logic                pready
);
  import ljpf_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("result changed while stalled");

  // a pair outside the cutoff carries no force
  a_zero_force: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.within_cutoff |->
      (out_item_o.force_x == F_ZERO) && (out_item_o.force_y == F_ZERO) &&
      (out_item_o.force_z == F_ZERO))
    else $error("force outside cutoff");

  // the energy sum only moves on a pair inside the cutoff or a new pass
  a_sum_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i ##1 out_valid_o && !out_item_o.within_cutoff &&
      $changed(out_item_o.out_first_atom) |->
      (out_item_o.energy_total == $past(out_item_o.energy_total)) ||
      (out_item_o.energy_total == F_ZERO))
    else $error("energy moved outside cutoff");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel |-> pready)
    else $error("config port stalled");

endmodule

bind lj_pair_force_top ljpf_checker u_ljpf_checker (.*);
